/* sv/fracalu_pkg.sv */
`timescale 1ns / 1ps

package fracalu_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int OP_W          = 2;
    localparam int RES_NUM_W     = 33;
    localparam int RES_DEN_W     = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_ZERO_DEN,
        ST_DIV_ZERO
    } t_status;

    // which cross product the shared multiplier forms this cycle
    typedef enum logic [1:0] {
        MUL_FIRST,
        MUL_SECOND,
        MUL_DEN
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic gcd_done;
        logic no_div;
        logic div_done;
    } t_dp_stat;

endpackage

/* sv/fracalu_dp.sv */
`timescale 1ns / 1ps

module fracalu_dp #(
    parameter int OPERAND_WIDTH = fracalu_pkg::OPERAND_WIDTH
) (
    input  logic                                   i_clk,
    input  fracalu_pkg::t_dp_cmd                   i_cmd,
    output fracalu_pkg::t_dp_stat                  o_stat,
    input  logic [fracalu_pkg::OP_W-1:0]           i_op,
    input  logic signed [OPERAND_WIDTH-1:0]        i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]        i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]        i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]        i_b_den,
    output logic signed [fracalu_pkg::RES_NUM_W-1:0] o_res_num,
    output logic signed [fracalu_pkg::RES_DEN_W-1:0] o_res_den,
    output logic [fracalu_pkg::STATUS_W-1:0]       o_status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    // sum of two products needs one more bit; wraps at 64 bits
    localparam int IW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int KW = $clog2(IW + 1);
    localparam int CW = $clog2(IW);

    fracalu_pkg::t_op     r_op;
    fracalu_pkg::t_status r_status;
    logic signed [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0] r_p0, r_p1;
    logic signed [IW-1:0] r_n, r_d;
    logic [IW-1:0]        r_u, r_v, r_g;
    logic [KW-1:0]        r_k;
    logic                 r_reduce;
    logic [IW-1:0]        r_qn, r_qd;
    logic [IW:0]          r_rn, r_rd;
    logic [CW-1:0]        r_cnt;
    logic                 r_divided;
    logic signed [fracalu_pkg::RES_NUM_W-1:0] r_res_num;
    logic signed [fracalu_pkg::RES_DEN_W-1:0] r_res_den;
    fracalu_pkg::t_status r_res_status;

    function automatic logic [IW-1:0] mag_of(input logic signed [IW-1:0] v);
        return v[IW-1] ? IW'(~v + 1'b1) : IW'(v);
    endfunction

    // shared multiplier
    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        case (i_cmd.mul_sel)
            fracalu_pkg::MUL_FIRST: begin
                mul_x = r_an;
                mul_y = (r_op == fracalu_pkg::OP_MUL) ? r_bn : r_bd;
            end
            fracalu_pkg::MUL_SECOND: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            fracalu_pkg::MUL_DEN: begin
                mul_x = r_ad;
                mul_y = (r_op == fracalu_pkg::OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_x = r_an;
                mul_y = r_bd;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // numerator combine
    logic signed [IW-1:0] e0, e1, n_sum;
    assign e0 = IW'(r_p0);
    assign e1 = IW'(r_p1);

    always_comb begin
        case (r_op)
            fracalu_pkg::OP_ADD: n_sum = e0 + e1;
            fracalu_pkg::OP_SUB: n_sum = e0 - e1;
            default:             n_sum = e0;
        endcase
    end

    // binary gcd step
    logic          u_even, v_even, u_ge_v;
    logic [IW-1:0] gcd_diff, uv_or, g_full;
    assign u_even   = ~r_u[0];
    assign v_even   = ~r_v[0];
    assign u_ge_v   = r_u >= r_v;
    assign gcd_diff = u_ge_v ? (r_u - r_v) : (r_v - r_u);
    assign uv_or    = r_u | r_v;
    assign g_full   = uv_or << r_k;

    // restoring divide, numerator and denominator lanes share the divisor
    logic [IW:0] rn_sh, rd_sh, g_ext;
    logic        n_ge, d_ge;
    assign g_ext = {1'b0, r_g};
    assign rn_sh = {r_rn[IW-1:0], r_qn[IW-1]};
    assign rd_sh = {r_rd[IW-1:0], r_qd[IW-1]};
    assign n_ge  = rn_sh >= g_ext;
    assign d_ge  = rd_sh >= g_ext;

    logic signed [IW-1:0] qn_s, qd_s;
    assign qn_s = r_n[IW-1] ? -$signed(r_qn) : $signed(r_qn);
    assign qd_s = r_d[IW-1] ? -$signed(r_qd) : $signed(r_qd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= fracalu_pkg::t_op'(i_op);
            r_an      <= i_a_num;
            r_ad      <= i_a_den;
            r_bn      <= i_b_num;
            r_bd      <= i_b_den;
            r_divided <= 1'b0;
            if (i_a_den == '0 || i_b_den == '0) begin
                r_status <= fracalu_pkg::ST_ZERO_DEN;
            end else if (fracalu_pkg::t_op'(i_op) == fracalu_pkg::OP_DIV && i_b_num == '0) begin
                r_status <= fracalu_pkg::ST_DIV_ZERO;
            end else begin
                r_status <= fracalu_pkg::ST_OK;
            end
        end

        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                fracalu_pkg::MUL_FIRST:  r_p0 <= mul_p;
                fracalu_pkg::MUL_SECOND: r_p1 <= mul_p;
                fracalu_pkg::MUL_DEN:    r_d  <= IW'(mul_p);
                default:                 r_p0 <= mul_p;
            endcase
        end

        if (i_cmd.sum) begin
            r_n <= n_sum;
        end

        if (i_cmd.gcd_init) begin
            r_u      <= mag_of(r_n);
            r_v      <= mag_of(r_d);
            r_k      <= '0;
            r_reduce <= (r_n != '0) && (r_d != '0);
        end else if (i_cmd.gcd_step) begin
            if (u_even && v_even) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (u_even) begin
                r_u <= r_u >> 1;
            end else if (v_even) begin
                r_v <= r_v >> 1;
            end else if (u_ge_v) begin
                r_u <= gcd_diff;
            end else begin
                r_v <= gcd_diff;
            end
        end

        if (i_cmd.div_init) begin
            r_g       <= g_full;
            r_qn      <= mag_of(r_n);
            r_qd      <= mag_of(r_d);
            r_rn      <= '0;
            r_rd      <= '0;
            r_cnt     <= '0;
            r_divided <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_rn  <= n_ge ? (rn_sh - g_ext) : rn_sh;
            r_rd  <= d_ge ? (rd_sh - g_ext) : rd_sh;
            r_qn  <= {r_qn[IW-2:0], n_ge};
            r_qd  <= {r_qd[IW-2:0], d_ge};
            r_cnt <= r_cnt + 1'b1;
        end

        if (i_cmd.out_load) begin
            r_res_status <= r_status;
            if (r_status != fracalu_pkg::ST_OK) begin
                r_res_num <= '0;
                r_res_den <= '0;
            end else if (r_divided) begin
                r_res_num <= fracalu_pkg::RES_NUM_W'(qn_s);
                r_res_den <= fracalu_pkg::RES_DEN_W'(qd_s);
            end else begin
                r_res_num <= fracalu_pkg::RES_NUM_W'(r_n);
                r_res_den <= fracalu_pkg::RES_DEN_W'(r_d);
            end
        end
    end

    assign o_stat.err      = (r_status != fracalu_pkg::ST_OK);
    assign o_stat.gcd_done = (r_u == '0) || (r_v == '0);
    // gcd of one: the division would give back the same fraction
    assign o_stat.no_div   = !r_reduce || (uv_or == IW'(1) && r_k == '0);
    assign o_stat.div_done = (r_cnt == CW'(IW - 1));

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_res_status;

endmodule

/* sv/fracalu_ctrl.sv */
`timescale 1ns / 1ps

module fracalu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fracalu_pkg::t_dp_cmd  o_cmd,
    input  fracalu_pkg::t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GINIT,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = fracalu_pkg::MUL_FIRST;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fracalu_pkg::MUL_SECOND;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fracalu_pkg::MUL_DEN;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_GINIT;
            end
            S_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                if (!i_stat.gcd_done) begin
                    o_cmd.gcd_step = 1'b1;
                end else if (i_stat.no_div) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/fraction_alu_reduce_unit.sv */
`timescale 1ns / 1ps

// Rational add/sub/mul/div of two signed fractions, result reduced by the gcd of
// its magnitudes (signs kept as computed; a zero numerator is left unreduced). One
// beat is worked on at a time; the next input beat is taken as soon as the result
// moves to the output register. With IW = min(2*OPERAND_WIDTH+1, 64), a beat is
// accepted, takes three products in turn on the one shared multiplier, combines
// them and seeds the gcd, runs the binary-gcd steps (data dependent) and a check
// that they have finished, then an IW-bit bit-serial division when the gcd
// exceeds one and the numerator is not zero, and last moves into the output
// register. A zero denominator or a divide by a zero fraction skips to the output.
module fraction_alu_reduce_unit #(
    parameter int OPERAND_WIDTH = fracalu_pkg::OPERAND_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [fracalu_pkg::OP_W-1:0]             i_op,
    input  logic signed [OPERAND_WIDTH-1:0]          i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]          i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]          i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]          i_b_den,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [fracalu_pkg::RES_NUM_W-1:0] o_res_num,
    output logic signed [fracalu_pkg::RES_DEN_W-1:0] o_res_den,
    output logic [fracalu_pkg::STATUS_W-1:0]         o_status
);

    fracalu_pkg::t_dp_cmd  cmd;
    fracalu_pkg::t_dp_stat stat;

    fracalu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    fracalu_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_op      (i_op),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // one beat in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input taken again while a beat is in flight");

    // result never appears the cycle after its input beat
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !$rose(o_out_valid))
        else $error("result valid too early");

    // error beats carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != fracalu_pkg::ST_OK)
            |-> (o_res_num == '0 && o_res_den == '0))
        else $error("error result with nonzero fields");

endmodule

/* verif/fraction_alu_reduce_checker.sv */
`timescale 1ns / 1ps

module fraction_alu_reduce_checker (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_in_valid,
    input  logic                                            i_in_ready,
    input  logic [fracalu_pkg::OP_W-1:0]                    i_op,
    input  logic signed [fracalu_pkg::OPERAND_WIDTH-1:0]    i_a_num,
    input  logic signed [fracalu_pkg::OPERAND_WIDTH-1:0]    i_a_den,
    input  logic signed [fracalu_pkg::OPERAND_WIDTH-1:0]    i_b_num,
    input  logic signed [fracalu_pkg::OPERAND_WIDTH-1:0]    i_b_den,
    input  logic                                            i_out_valid,
    input  logic                                            i_out_ready,
    input  logic signed [fracalu_pkg::RES_NUM_W-1:0]        i_res_num,
    input  logic signed [fracalu_pkg::RES_DEN_W-1:0]        i_res_den,
    input  logic [fracalu_pkg::STATUS_W-1:0]                i_status,
    output int                                              o_fail_count,
    output int                                              o_pending
);

    typedef struct {
        logic signed [fracalu_pkg::RES_NUM_W-1:0] num;
        logic signed [fracalu_pkg::RES_DEN_W-1:0] den;
        fracalu_pkg::t_status                     status;
    } t_frac_res;

    t_frac_res want_q[$];
    t_frac_res want;
    int        fails = 0;

    // operands arrive already sign-extended to 64 bits; products stay well inside
    function automatic t_frac_res reduce_fraction(fracalu_pkg::t_op op,
                                                  longint an, longint ad,
                                                  longint bn, longint bd);
        t_frac_res r;
        longint    n;
        longint    d;
        longint    n_mag;
        longint    d_mag;
        longint    g;
        longint    rem;
        longint    tmp;
        r.num    = '0;
        r.den    = '0;
        r.status = fracalu_pkg::ST_OK;
        if (ad == 0 || bd == 0) begin
            r.status = fracalu_pkg::ST_ZERO_DEN;
            return r;
        end
        if (op == fracalu_pkg::OP_DIV && bn == 0) begin
            r.status = fracalu_pkg::ST_DIV_ZERO;
            return r;
        end
        case (op)
            fracalu_pkg::OP_ADD: begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            fracalu_pkg::OP_SUB: begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            fracalu_pkg::OP_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        n_mag = (n < 0) ? -n : n;
        d_mag = (d < 0) ? -d : d;
        // zero on either side: left unreduced
        if (n_mag != 0 && d_mag != 0) begin
            g   = n_mag;
            rem = d_mag;
            while (rem != 0) begin
                tmp = g % rem;
                g   = rem;
                rem = tmp;
            end
            n = n / g;
            d = d / g;
        end
        r.num = n[fracalu_pkg::RES_NUM_W-1:0];
        r.den = d[fracalu_pkg::RES_DEN_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                want_q.push_back(reduce_fraction(fracalu_pkg::t_op'(i_op), i_a_num,
                                                 i_a_den, i_b_num, i_b_den));
            if (i_out_valid && i_out_ready) begin
                if (want_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with nothing pending: %0d/%0d st %0d",
                                 $realtime, i_res_num, i_res_den, i_status);
                end else begin
                    want = want_q.pop_front();
                    if (i_res_num !== want.num || i_res_den !== want.den ||
                        i_status !== want.status) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch exp %0d/%0d st %0d, got %0d/%0d st %0d",
                                     $realtime, want.num, want.den, want.status,
                                     i_res_num, i_res_den, i_status);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= want_q.size();
    end

endmodule

/* verif/tb_fraction_alu_reduce_unit.sv */
`timescale 1ns / 1ps

module tb_fraction_alu_reduce_unit;

    localparam int OW             = fracalu_pkg::OPERAND_WIDTH;
    localparam int RANDOM_ITEMS   = 1230;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int QUIET_FIRST    = 500;
    localparam int QUIET_LAST     = 700;

    localparam logic signed [OW-1:0] MOST_NEG = {1'b1, {(OW-1){1'b0}}};
    localparam logic signed [OW-1:0] MOST_POS = {1'b0, {(OW-1){1'b1}}};

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n;
    logic                                     i_in_valid;
    logic                                     o_in_ready;
    logic [fracalu_pkg::OP_W-1:0]             i_op;
    logic signed [OW-1:0]                     i_a_num;
    logic signed [OW-1:0]                     i_a_den;
    logic signed [OW-1:0]                     i_b_num;
    logic signed [OW-1:0]                     i_b_den;
    logic                                     o_out_valid;
    logic                                     i_out_ready;
    logic signed [fracalu_pkg::RES_NUM_W-1:0] o_res_num;
    logic signed [fracalu_pkg::RES_DEN_W-1:0] o_res_den;
    logic [fracalu_pkg::STATUS_W-1:0]         o_status;

    logic quiet;
    int   fail_count;
    int   pending;
    int   stuck_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fraction_alu_reduce_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_status    (o_status)
    );

    fraction_alu_reduce_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_res_num    (o_res_num),
        .i_res_den    (o_res_den),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 11);
    end

    // any beat on either side resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[fraction_alu_reduce_unit] ERROR");
            $finish;
        end
    end

    function automatic logic signed [OW-1:0] random_operand();
        logic signed [OW-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       v = MOST_NEG;
                    1:       v = '1;
                    2:       v = '0;
                    3:       v = 1;
                    default: v = MOST_POS;
                endcase
            end
            // small: lots of common factors
            1, 2, 3: v = OW'(int'($urandom_range(80)) - 40);
            default: v = OW'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic signed [OW-1:0] random_den();
        logic signed [OW-1:0] v;
        if ($urandom_range(99) < 2)
            return '0;
        v = random_operand();
        return (v == '0) ? OW'(1) : v;
    endfunction

    task automatic pause_sender();
        int gap;
        gap = 0;
        if (!quiet) begin
            if ($urandom_range(99) < 11)
                gap = $urandom_range(1, 12);
            // long gaps land the next beat on various phases of the gcd loop
            if ($urandom_range(99) < 4)
                gap = $urandom_range(20, 120);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fraction(input fracalu_pkg::t_op op,
                                 input logic signed [OW-1:0] an,
                                 input logic signed [OW-1:0] ad,
                                 input logic signed [OW-1:0] bn,
                                 input logic signed [OW-1:0] bd);
        pause_sender();
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_a_num    <= an;
        i_a_den    <= ad;
        i_b_num    <= bn;
        i_b_den    <= bd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= fracalu_pkg::OP_ADD;
        i_a_num     <= '0;
        i_a_den     <= '0;
        i_b_num     <= '0;
        i_b_den     <= '0;
        quiet       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_fraction(fracalu_pkg::OP_ADD, 1, 2, 1, 3);
        send_fraction(fracalu_pkg::OP_SUB, 1, 2, 1, 3);
        send_fraction(fracalu_pkg::OP_MUL, 2, 3, 3, 4);
        send_fraction(fracalu_pkg::OP_DIV, 1, 2, 3, 4);
        // numerator reaches 2^31
        send_fraction(fracalu_pkg::OP_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        send_fraction(fracalu_pkg::OP_SUB, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG);
        send_fraction(fracalu_pkg::OP_MUL, MOST_NEG, 1, MOST_NEG, 1);
        send_fraction(fracalu_pkg::OP_DIV, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
        send_fraction(fracalu_pkg::OP_ADD, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
        send_fraction(fracalu_pkg::OP_ADD, 5, 0, 1, 1);
        send_fraction(fracalu_pkg::OP_MUL, 1, 1, 1, 0);
        // zero denominator wins over divide by zero
        send_fraction(fracalu_pkg::OP_DIV, 1, 0, 0, 1);
        send_fraction(fracalu_pkg::OP_DIV, 3, 4, 0, 5);
        // zero numerators keep their denominator
        send_fraction(fracalu_pkg::OP_ADD, 0, 5, 0, 7);
        send_fraction(fracalu_pkg::OP_MUL, 0, 6, 3, 4);
        send_fraction(fracalu_pkg::OP_SUB, 3, 7, 3, 7);
        // signs stay as computed
        send_fraction(fracalu_pkg::OP_ADD, 1, -2, 1, -2);
        send_fraction(fracalu_pkg::OP_DIV, -1, -1, -1, -1);
        send_fraction(fracalu_pkg::OP_DIV, 1, 1, MOST_NEG, 1);
        send_fraction(fracalu_pkg::OP_SUB, MOST_NEG, 1, MOST_POS, 1);
        send_fraction(fracalu_pkg::OP_MUL, -1, 3, 3, -1);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            quiet <= (k >= QUIET_FIRST && k < QUIET_LAST);
            send_fraction(fracalu_pkg::t_op'($urandom_range(3)), random_operand(),
                          random_den(), random_operand(), random_den());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[fraction_alu_reduce_unit] OK");
        else
            $display("[fraction_alu_reduce_unit] ERROR");
        $finish;
    end

endmodule
